@@ rtl/core/ftjb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_pkg: shared types and constants
// Op codes, event codes, link states and defaults for the jitter buffer.
// ----------------------------------------------------------------------------
package ftjb_pkg;
  localparam int RING_DEPTH_DEF = 64;
  localparam int FRAME_BITS_DEF = 24;
  localparam int FRAME_W = 24;

  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_READY   = 2'd1,
    OP_INPUT   = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_ACCEPT     = 3'd0,
    EV_START      = 3'd1,
    EV_SPEED_UP   = 3'd2,
    EV_SLOW_DOWN  = 3'd3,
    EV_HOLD       = 3'd4,
    EV_DISCONNECT = 3'd5,
    EV_END_GAME   = 3'd6,
    EV_FRAME_DONE = 3'd7
  } ev_t;

  typedef enum logic [1:0] {
    LINK_OPEN    = 2'd0,
    LINK_PENDING = 2'd1,
    LINK_ACTIVE  = 2'd2
  } link_t;

  localparam logic [1:0] REG_TIMEOUT   = 2'd0;
  localparam logic [1:0] REG_LEAD_LOW  = 2'd1;
  localparam logic [1:0] REG_LEAD_HIGH = 2'd2;

  // one queued command between front and back
  typedef struct packed {
    op_t              op;
    logic             slot;
    logic [FRAME_W-1:0] frame;
    logic             move_up;
    logic             press_down;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic               slot_res;
    ev_t                event_res;
    logic               chosen_up;
    logic               chosen_down;
    logic               missed;
    logic [FRAME_W-1:0] frame_out;
    logic               last;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/core/ftjb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_in_if / ftjb_out_if: valid/ready channels
// Input item channel and result channel of the jitter buffer.
// ----------------------------------------------------------------------------
interface ftjb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        slot;
  logic [23:0] frame;
  logic        move_up;
  logic        press_down;
  modport source (output valid, op, slot, frame, move_up, press_down, input ready);
  modport sink (input valid, op, slot, frame, move_up, press_down, output ready);
endinterface

interface ftjb_out_if;
  logic        valid;
  logic        ready;
  logic        slot_res;
  logic [2:0]  event_res;
  logic        chosen_up;
  logic        chosen_down;
  logic        missed;
  logic [23:0] frame_out;
  logic        last;
  modport source (output valid, slot_res, event_res, chosen_up, chosen_down, missed,
                  frame_out, last, input ready);
  modport sink (input valid, slot_res, event_res, chosen_up, chosen_down, missed,
                frame_out, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/frame_tagged_input_jitter_buffer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_tagged_input_jitter_buffer_unit: two-slot input jitter buffer
// Connection control and frame-tagged input rings for two clients.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries connect, ready, tagged input and tick items; out_ch carries
//   result beats, the final beat of an item marked by last. Registers are
//   written over the APB port; write them only while the block is idle,
//   which the block itself does not enforce. A four-deep command queue
//   decouples input from the engine, so input beats are taken while the
//   engine works or a result waits. A tagged input reads its ring entry
//   and writes it unless it already holds that frame; a connect sends its
//   accept beat; an idle tick sends one disconnect beat per timed-out slot.
//   An active tick scans each slot's ring through its single ram port, one
//   entry a cycle, then sends a result beat per slot and a frame done beat,
//   or a disconnect and end game pair when a slot lags past the ring depth.
//   Reset clears link states, countdowns, frame and ring valid bits at once.
//   A stalled receiver holds the output register; the engine then waits
//   and the queue fills until in_ch.ready drops.
// ----------------------------------------------------------------------------
module frame_tagged_input_jitter_buffer_unit
  import ftjb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ftjb_in_if.sink          in_ch,
  ftjb_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  logic        cmd_valid, cmd_pop;
  cmd_t        cmd;
  logic [15:0] timeout;
  logic [5:0]  lead_low, lead_high;

  ftjb_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .timeout, .lead_low, .lead_high);

  ftjb_front u_front (
    .clk, .rst, .in_ch, .cmd_valid, .cmd, .cmd_pop);

  ftjb_back #(.RING_DEPTH(RING_DEPTH), .FRAME_BITS(FRAME_BITS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .timeout, .lead_low, .lead_high,
    .out_ch);
endmodule
`default_nettype wire

@@ rtl/core/ftjb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_ram: generic single-port ram
// One access per cycle, registered read data that shows the old word on a write.
// ----------------------------------------------------------------------------
module ftjb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/ftjb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_front: input stage and command queue
// Accepts input beats and holds them in a short fifo for the back end.
// ----------------------------------------------------------------------------
module ftjb_front
  import ftjb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  ftjb_in_if.sink   in_ch,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  wire logic cmd_pop
);
  localparam int QD = 4;
  cmd_t       q [QD];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       push;
  cmd_t       c_in;

  assign in_ch.ready = (cnt != 3'(QD));
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (cnt != 3'd0);
  assign cmd = q[rp];

  always_comb begin
    c_in.op         = op_t'(in_ch.op);
    c_in.slot       = in_ch.slot;
    c_in.frame      = in_ch.frame;
    c_in.move_up    = in_ch.move_up;
    c_in.press_down = in_ch.press_down;
  end

  // fifo storage
  always_ff @(posedge clk) begin
    if (push) q[wp] <= c_in;
  end

  // fifo pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (cmd_pop) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(cmd_pop);
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ftjb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_back: command engine
// Runs queued commands against link state and the frame rings, and emits
// result beats through a one-entry output register.
// ----------------------------------------------------------------------------
module ftjb_back
  import ftjb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  wire logic [15:0] timeout,
  input  wire logic [5:0]  lead_low,
  input  wire logic [5:0]  lead_high,
  ftjb_out_if.source       out_ch
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int RW = FRAME_BITS + 2;
  localparam int XW = FRAME_BITS + 2;
  localparam logic [FRAME_BITS-1:0] FMAX = '1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_INRD  = 9'b000000010,
    S_INWR  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_PICK  = 9'b000010000,
    S_EMIT  = 9'b000100000,
    S_CLEAR = 9'b001000000,
    S_IDLT  = 9'b010000000,
    S_WAIT  = 9'b100000000
  } st_t;

  st_t st;
  cmd_t cur;
  link_t link [2];
  logic [15:0] cd [2];
  logic [FRAME_BITS-1:0] cframe;
  logic [RING_DEPTH-1:0] vld [2];

  // frame of the current command at the internal width
  logic [FRAME_BITS-1:0] cur_fr;
  assign cur_fr = FRAME_BITS'(cur.frame);

  // ring ram, one per slot
  logic         we [2];
  logic [AW-1:0] addr;
  logic [RW-1:0] wdata;
  logic [RW-1:0] rdata [2];

  for (genvar g = 0; g < 2; g++) begin : g_ring
    ftjb_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_ram (
      .clk(clk), .we(we[g]), .addr(addr), .wdata(wdata), .rdata(rdata[g]));
  end

  // scan bookkeeping
  logic          s;
  logic [AW:0]   k;
  logic [AW-1:0] kd;
  logic          kd_v;
  logic          any, found;
  logic [FRAME_BITS-1:0] newest, chosen;
  logic [AW-1:0] pick;

  // pending result beats
  res_t ob;
  logic ob_v;
  logic ob_load;
  res_t pend [3];
  logic [1:0] pn, pi;

  logic [FRAME_BITS-1:0] rf;
  assign rf = rdata[s][FRAME_BITS+1:2];

  assign out_ch.valid       = ob_v;
  assign out_ch.slot_res    = ob.slot_res;
  assign out_ch.event_res   = ob.event_res;
  assign out_ch.chosen_up   = ob.chosen_up;
  assign out_ch.chosen_down = ob.chosen_down;
  assign out_ch.missed      = ob.missed;
  assign out_ch.frame_out   = ob.frame_out;
  assign out_ch.last        = ob.last;

  assign cmd_pop = (st == S_IDLE) && cmd_valid;
  assign ob_load = (st == S_WAIT) && (pi != pn) && (!ob_v || out_ch.ready);

  function automatic res_t mk(logic sl, ev_t ev, logic u, logic d, logic m,
                              logic [FRAME_BITS-1:0] f);
    res_t r;
    r.slot_res = sl; r.event_res = ev; r.chosen_up = u; r.chosen_down = d;
    r.missed = m; r.frame_out = 24'(f); r.last = 1'b0;
    return r;
  endfunction

  // lead and lag arithmetic, extended signed
  logic signed [XW-1:0] lead, lag;
  ev_t req;
  always_comb begin
    lead = $signed({2'b00, newest}) - $signed({2'b00, cframe});
    lag  = found ? ($signed({2'b00, cframe}) - $signed({2'b00, chosen}))
                 : ($signed({2'b00, cframe}) + XW'(1));
    if (lead < $signed(XW'(lead_low))) req = EV_SPEED_UP;
    else if (lead > $signed(XW'(lead_high))) req = EV_SLOW_DOWN;
    else req = EV_HOLD;
  end

  // ram address and write control
  always_comb begin
    we[0] = 1'b0; we[1] = 1'b0;
    addr = cur_fr[AW-1:0];
    wdata = {cur_fr, cur.move_up, cur.press_down};
    case (st)
      S_INWR: we[cur.slot] = !(vld[cur.slot][cur_fr[AW-1:0]] &&
                               rdata[cur.slot][FRAME_BITS+1:2] == cur_fr);
      S_SCAN: addr = k[AW-1:0];
      S_PICK: addr = pick;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_v <= 1'b0;
    end else if (ob_load) begin
      ob   <= res_t'({pend[pi][$bits(res_t)-1:1], ((pi + 2'd1) == pn)});
      ob_v <= 1'b1;
    end else if (out_ch.ready) begin
      ob_v <= 1'b0;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; pn <= '0; pi <= '0;
      link[0] <= LINK_OPEN; link[1] <= LINK_OPEN;
      cd[0] <= '0; cd[1] <= '0; cframe <= '0;
      vld[0] <= '0; vld[1] <= '0;
      s <= 1'b0; k <= '0; kd_v <= 1'b0;
    end else begin
      case (st)
        S_IDLE: if (cmd_valid) begin
          cur <= cmd;
          case (cmd.op)
            OP_CONNECT: begin
              cd[cmd.slot] <= timeout;
              if (link[cmd.slot] == LINK_OPEN) link[cmd.slot] <= LINK_PENDING;
              pend[0] <= mk(cmd.slot, EV_ACCEPT, 1'b0, 1'b0, 1'b0, cframe);
              pn <= 2'd1; pi <= '0; st <= S_WAIT;
            end
            OP_READY: begin
              cd[cmd.slot] <= timeout;
              if (link[cmd.slot] == LINK_PENDING) link[cmd.slot] <= LINK_ACTIVE;
            end
            OP_INPUT: st <= S_INRD;
            default: begin
              pn <= '0; pi <= '0;
              if (link[0] == LINK_ACTIVE && link[1] == LINK_ACTIVE) begin
                s <= 1'b0; k <= '0; kd_v <= 1'b0; any <= 1'b0; found <= 1'b0;
                pick <= '0;
                st <= S_SCAN;
              end else st <= S_IDLT;
            end
          endcase
        end
        S_INRD: st <= S_INWR;
        S_INWR: begin
          vld[cur.slot][cur_fr[AW-1:0]] <= 1'b1;
          st <= S_IDLE;
        end
        S_SCAN: begin
          // one entry issued per cycle, evaluated in the next cycle
          if (kd_v && vld[s][kd]) begin
            any <= 1'b1;
            if (!any || rf > newest) newest <= rf;
            if (rf <= cframe && (!found || rf > chosen)) begin
              chosen <= rf; pick <= kd; found <= 1'b1;
            end
          end
          kd <= k[AW-1:0];
          kd_v <= (k != (AW+1)'(RING_DEPTH));
          if (k != (AW+1)'(RING_DEPTH)) k <= k + 1'b1;
          else if (!kd_v) st <= S_PICK;
        end
        S_PICK: st <= S_EMIT;
        S_EMIT: begin
          if (any && lag > $signed(XW'(RING_DEPTH))) begin
            pend[pn] <= mk(s, EV_DISCONNECT, 1'b0, 1'b0, 1'b0, cframe);
            pend[pn+2'd1] <= mk(~s, EV_END_GAME, 1'b0, 1'b0, 1'b0, cframe);
            pn <= pn + 2'd2;
            link[s] <= LINK_OPEN;
            st <= S_CLEAR;
          end else begin
            // an unwritten entry reads as cleared controls
            if (!any) pend[pn] <= mk(s, EV_START, 1'b0, 1'b0, 1'b0, cframe);
            else pend[pn] <= mk(s, req, rdata[s][1] & vld[s][pick],
                                rdata[s][0] & vld[s][pick],
                                !found || (chosen != cframe), cframe);
            if (s == 1'b0) begin
              s <= 1'b1; k <= '0; kd_v <= 1'b0; any <= 1'b0; found <= 1'b0;
              pick <= '0;
              pn <= pn + 2'd1;
              st <= S_SCAN;
            end else begin
              pend[pn+2'd1] <= mk(1'b0, EV_FRAME_DONE, 1'b0, 1'b0, 1'b0, cframe);
              pn <= pn + 2'd2;
              if (cframe != FMAX) cframe <= cframe + 1'b1;
              st <= S_WAIT;
            end
          end
        end
        S_CLEAR: begin
          vld[0] <= '0; vld[1] <= '0; cframe <= '0; st <= S_WAIT;
        end
        S_IDLT: begin
          cframe <= '0;
          begin : idle_blk
            logic [1:0] n;
            n = '0;
            for (int i = 0; i < 2; i++) begin
              if (link[i] == LINK_ACTIVE && cd[i] <= 16'd1) begin
                link[i] <= LINK_OPEN;
                pend[n] <= mk(i[0], EV_DISCONNECT, 1'b0, 1'b0, 1'b0, '0);
                n = n + 2'd1;
              end
              if (link[i] == LINK_ACTIVE && cd[i] != 16'd0) cd[i] <= cd[i] - 16'd1;
            end
            pn <= n;
          end
          st <= S_WAIT;
        end
        S_WAIT: begin
          if (pi == pn) st <= S_IDLE;
          else if (ob_load) pi <= pi + 2'd1;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ftjb_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_cfg: register file
// APB-style access to timeout and lead thresholds.
// ----------------------------------------------------------------------------
module ftjb_cfg
  import ftjb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [15:0] timeout,
  output logic      [5:0]  lead_low,
  output logic      [5:0]  lead_high
);
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= 16'd300; lead_low <= 6'd3; lead_high <= 6'd6;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_TIMEOUT:   timeout   <= pwdata[15:0];
        REG_LEAD_LOW:  lead_low  <= pwdata[5:0];
        REG_LEAD_HIGH: lead_high <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT:   prdata = {16'd0, timeout};
      REG_LEAD_LOW:  prdata = {26'd0, lead_low};
      REG_LEAD_HIGH: prdata = {26'd0, lead_high};
      default:       prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/core/ftjb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ftjb_checker: port-level checks
// Watches the result channel over time.
// ----------------------------------------------------------------------------
module ftjb_checker
  import ftjb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_event,
  input wire logic [23:0] out_frame,
  input wire logic        out_last,
  input wire logic        pready
);
  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_frame))
    else $error("result beat changed under stall");

  // frame done is always the last beat of its item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_FRAME_DONE |-> out_last)
    else $error("frame done not last");

  // accept is a single-beat item
  a_acc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_event == EV_ACCEPT |-> out_last)
    else $error("accept not last");

  // nothing shows in the cycle after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind frame_tagged_input_jitter_buffer_unit ftjb_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_event(out_ch.event_res), .out_frame(out_ch.frame_out),
  .out_last(out_ch.last), .pready(pready));
`default_nettype wire

@@ verif/frame_tagged_input_jitter_buffer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_tagged_input_jitter_buffer_unit_tb: self-checking bench for the buffer
// Drives connect, ready, tagged input and tick beats in bursts with random
// gaps, models link states, rings and frame pacing, and compares every result
// beat in order against the model, under receiver stalls and a long hold-off.
// ----------------------------------------------------------------------------
module frame_tagged_input_jitter_buffer_unit_tb;
  import ftjb_pkg::*;

  localparam int DEPTH = 64;
  localparam logic [23:0] FMAX = 24'hFFFFFF;
  localparam int WD_LIMIT = 20000;
  localparam int SETTLE = 400;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  ftjb_in_if in_ch ();
  ftjb_out_if out_ch ();

  frame_tagged_input_jitter_buffer_unit u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // buffer model state
  logic        ring_vld [2][DEPTH];
  logic [23:0] ring_frm [2][DEPTH];
  logic        ring_up  [2][DEPTH];
  logic        ring_dn  [2][DEPTH];
  link_t       link_st [2];
  logic [15:0] countdown [2];
  logic [23:0] cur_frame;
  logic [15:0] timeout_ticks;
  logic [5:0]  lead_lo, lead_hi;

  res_t expected_beats[$];
  int   errors = 0;
  int   items_sent = 0;
  int   beats_seen = 0;
  int   drops_seen = 0;
  int   burst_left = 0;
  bit   gaps_on = 1;
  bit   hold_req = 0;
  int   wd_cnt = 0;

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // model helpers
  function automatic res_t mk_beat(logic s, ev_t ev, logic up, logic dn, logic miss);
    res_t r;
    r.slot_res = s; r.event_res = ev; r.chosen_up = up; r.chosen_down = dn;
    r.missed = miss; r.frame_out = cur_frame; r.last = 1'b0;
    return r;
  endfunction

  task automatic clear_rings();
    for (int s = 0; s < 2; s++)
      for (int k = 0; k < DEPTH; k++) begin
        ring_vld[s][k] = 0; ring_frm[s][k] = '0; ring_up[s][k] = 0; ring_dn[s][k] = 0;
      end
  endtask

  // pacing tick while both slots are active
  task automatic pace_tick(ref res_t beats[$]);
    bit any, found, dropped;
    longint newest, chosen, lead;
    int pick;
    ev_t req;
    dropped = 0;
    for (int s = 0; s < 2 && !dropped; s++) begin
      any = 0; found = 0; newest = 0; chosen = -1; pick = 0;
      for (int k = 0; k < DEPTH; k++) begin
        if (ring_vld[s][k]) begin
          if (!any || longint'(ring_frm[s][k]) > newest) newest = ring_frm[s][k];
          any = 1;
          if (ring_frm[s][k] <= cur_frame && (!found || longint'(ring_frm[s][k]) > chosen)) begin
            chosen = ring_frm[s][k]; pick = k; found = 1;
          end
        end
      end
      if (!any) begin
        beats.push_back(mk_beat(s[0], EV_START, 0, 0, 0));
      end else begin
        lead = newest - longint'(cur_frame);
        if (lead < longint'(lead_lo)) req = EV_SPEED_UP;
        else if (lead > longint'(lead_hi)) req = EV_SLOW_DOWN;
        else req = EV_HOLD;
        if (longint'(cur_frame) - chosen > DEPTH) begin
          link_st[s] = LINK_OPEN;
          beats.push_back(mk_beat(s[0], EV_DISCONNECT, 0, 0, 0));
          beats.push_back(mk_beat(~s[0], EV_END_GAME, 0, 0, 0));
          clear_rings();
          cur_frame = '0;
          dropped = 1;
        end else begin
          beats.push_back(mk_beat(s[0], req, ring_up[s][pick], ring_dn[s][pick],
                                  chosen != longint'(cur_frame)));
        end
      end
    end
    if (!dropped) begin
      beats.push_back(mk_beat(1'b0, EV_FRAME_DONE, 0, 0, 0));
      if (cur_frame != FMAX) cur_frame = cur_frame + 24'd1;
    end
  endtask

  // apply one accepted item to the model and queue its results
  task automatic predict_item(op_t op, logic s, logic [23:0] fr, logic up, logic dn);
    res_t beats[$];
    int k;
    case (op)
      OP_CONNECT: begin
        countdown[s] = timeout_ticks;
        if (link_st[s] == LINK_OPEN) link_st[s] = LINK_PENDING;
        beats.push_back(mk_beat(s, EV_ACCEPT, 0, 0, 0));
      end
      OP_READY: begin
        if (link_st[s] == LINK_PENDING) link_st[s] = LINK_ACTIVE;
        countdown[s] = timeout_ticks;
      end
      OP_INPUT: begin
        k = fr % DEPTH;
        if (!(ring_vld[s][k] && ring_frm[s][k] == fr)) begin
          ring_vld[s][k] = 1; ring_frm[s][k] = fr; ring_up[s][k] = up; ring_dn[s][k] = dn;
        end
      end
      default: begin
        if (link_st[0] == LINK_ACTIVE && link_st[1] == LINK_ACTIVE) begin
          pace_tick(beats);
        end else begin
          cur_frame = '0;
          for (int i = 0; i < 2; i++) begin
            if (link_st[i] == LINK_ACTIVE) begin
              if (countdown[i] > 0) countdown[i] = countdown[i] - 16'd1;
              if (countdown[i] == 0) begin
                link_st[i] = LINK_OPEN;
                beats.push_back(mk_beat(i[0], EV_DISCONNECT, 0, 0, 0));
              end
            end
          end
        end
      end
    endcase
    if (beats.size() > 0) beats[beats.size()-1].last = 1'b1;
    foreach (beats[i]) expected_beats.push_back(beats[i]);
  endtask

  // send one item; sender runs in bursts with random gaps
  task automatic send_item(op_t op, logic s, logic [23:0] fr, logic up, logic dn);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid = 0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_ch.valid = 1; in_ch.op = op; in_ch.slot = s; in_ch.frame = fr;
    in_ch.move_up = up; in_ch.press_down = dn;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, s, fr, up, dn);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  // wait for every expected beat, then let queued silent items drain
  task automatic drain();
    stop_sending();
    while (expected_beats.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TIMEOUT:   timeout_ticks = val[15:0];
      REG_LEAD_LOW:  lead_lo = val[5:0];
      REG_LEAD_HIGH: lead_hi = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic set_config(logic [15:0] to, logic [5:0] lo, logic [5:0] hi);
    drain();
    reg_write(REG_TIMEOUT, {16'h0, to});
    reg_write(REG_LEAD_LOW, {26'h0, lo});
    reg_write(REG_LEAD_HIGH, {26'h0, hi});
  endtask

  function automatic logic [23:0] near_frame(int back, int ahead);
    return cur_frame + 24'($urandom_range(0, back + ahead)) - 24'(back);
  endfunction

  task automatic bring_up_both();
    for (int i = 0; i < 2; i++) begin
      if (link_st[i] == LINK_OPEN)
        send_item(OP_CONNECT, i[0], 24'($urandom), 1'($urandom), 1'($urandom));
      if (link_st[i] == LINK_PENDING)
        send_item(OP_READY, i[0], 24'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  // directed: connection flow, empty rings, extremes, duplicate frames
  task automatic test_directed();
    send_item(OP_TICK, 0, 24'h0, 0, 0);          // idle tick, nobody active
    send_item(OP_READY, 0, 24'h0, 0, 0);         // ready while open is ignored
    send_item(OP_CONNECT, 0, FMAX, 1, 1);
    send_item(OP_CONNECT, 0, 24'h0, 0, 0);       // repeat connect while pending
    send_item(OP_CONNECT, 1, 24'h0, 0, 0);
    send_item(OP_READY, 0, 24'h0, 1, 1);
    send_item(OP_READY, 1, FMAX, 0, 0);
    send_item(OP_TICK, 1, FMAX, 1, 1);           // both rings empty: start game
    send_item(OP_INPUT, 0, 24'd1, 1, 0);
    send_item(OP_INPUT, 0, 24'd1, 0, 1);         // same frame again is ignored
    send_item(OP_INPUT, 0, 24'd65, 0, 1);        // same index, new frame overwrites
    send_item(OP_INPUT, 1, FMAX, 1, 1);          // far ahead: slow down
    send_item(OP_INPUT, 1, 24'd0, 0, 1);
    send_item(OP_TICK, 0, 24'h0, 0, 0);
    send_item(OP_INPUT, 0, 24'd1, 1, 1);
    send_item(OP_INPUT, 0, 24'd2, 1, 0);
    send_item(OP_INPUT, 1, 24'd3, 0, 1);
    send_item(OP_TICK, 0, 24'h0, 0, 0);
    send_item(OP_TICK, 0, 24'h0, 0, 0);
    send_item(OP_TICK, 0, 24'h0, 0, 0);           // older frame only: missed
    send_item(OP_CONNECT, 1, 24'h0, 0, 0);        // connect while active reloads
    send_item(OP_TICK, 0, 24'h0, 0, 0);
  endtask

  // a slot starved of inputs lags past the ring depth and is dropped
  task automatic test_lag_drop();
    bring_up_both();
    send_item(OP_INPUT, 0, cur_frame, 1, 0);
    for (int i = 0; i < 75 && link_st[0] == LINK_ACTIVE; i++) begin
      send_item(OP_INPUT, 1, cur_frame + 24'd2, 1'($urandom), 1'($urandom));
      send_item(OP_TICK, 0, 24'h0, 0, 0);
    end
  endtask

  // one-tick timeout, then ticks and reloading connects with both slots active
  task automatic test_idle_timeout();
    set_config(16'd1, 6'd3, 6'd6);
    for (int i = 0; i < 2; i++) begin
      if (link_st[i] == LINK_OPEN) send_item(OP_CONNECT, i[0], 24'h0, 0, 0);
      if (link_st[i] == LINK_PENDING) send_item(OP_READY, i[0], 24'h0, 0, 0);
    end
    if (link_st[1] == LINK_ACTIVE) begin
      send_item(OP_CONNECT, 1, 24'h0, 0, 0);
    end
    send_item(OP_TICK, 0, 24'h0, 0, 0);
    send_item(OP_TICK, 0, 24'h0, 0, 0);
    send_item(OP_CONNECT, 0, 24'h0, 0, 0);
    send_item(OP_READY, 0, 24'h0, 0, 0);
    send_item(OP_TICK, 0, 24'h0, 0, 0);
  endtask

  // random sessions: mostly well-formed play with noise mixed in
  task automatic test_random_play(int n);
    int pick;
    logic s;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      s = 1'($urandom);
      if (pick < 8) begin
        send_item(op_t'($urandom_range(0, 3)), s, 24'($urandom), 1'($urandom),
                  1'($urandom));
      end else if (link_st[0] != LINK_ACTIVE || link_st[1] != LINK_ACTIVE) begin
        if (pick < 15) send_item(OP_TICK, s, 24'($urandom), 1'($urandom), 1'($urandom));
        else bring_up_both();
      end else if (pick < 60) begin
        send_item(OP_INPUT, s, near_frame(8, 14), 1'($urandom), 1'($urandom));
      end else if (pick < 65) begin
        send_item(OP_INPUT, s, 24'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_item(OP_TICK, s, 24'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    gaps_on = 0;
    bring_up_both();
    @(negedge clk);
    hold_req = 1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2) send_item(OP_TICK, 0, 24'h0, 0, 0);
      else send_item(OP_INPUT, i[0], near_frame(2, 6), 1'($urandom), 1'($urandom));
    end
    gaps_on = 1;
  endtask

  // receiver stall pattern and long hold-off
  initial begin
    int hold_cnt, stall_pct, phase_cnt;
    hold_cnt = 0; stall_pct = 0; phase_cnt = 0;
    out_ch.ready = 1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 1500;
      end
      if (phase_cnt == 0) begin
        phase_cnt = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      phase_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready = 0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: expected none actual event %0d slot %0d",
                 $realtime, out_ch.event_res, out_ch.slot_res);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (want.event_res == EV_DISCONNECT) drops_seen++;
        cmp_field("slot_res", want.slot_res, out_ch.slot_res);
        cmp_field("event_res", want.event_res, out_ch.event_res);
        cmp_field("chosen_up", want.chosen_up, out_ch.chosen_up);
        cmp_field("chosen_down", want.chosen_down, out_ch.chosen_down);
        cmp_field("missed", want.missed, out_ch.missed);
        cmp_field("frame_out", want.frame_out, out_ch.frame_out);
        cmp_field("last", want.last, out_ch.last);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      wd_cnt <= 0;
    end else begin
      wd_cnt <= wd_cnt + 1;
      if (wd_cnt == WD_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst = 1;
    in_ch.valid = 0; in_ch.op = '0; in_ch.slot = 0; in_ch.frame = '0;
    in_ch.move_up = 0; in_ch.press_down = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    clear_rings();
    link_st[0] = LINK_OPEN; link_st[1] = LINK_OPEN;
    countdown[0] = '0; countdown[1] = '0;
    cur_frame = '0;
    timeout_ticks = 16'd300; lead_lo = 6'd3; lead_hi = 6'd6;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    test_directed();
    test_lag_drop();
    test_idle_timeout();
    set_config(16'd300, 6'd3, 6'd6);
    test_random_play(70);
    test_backpressure();
    set_config(16'd65535, 6'd63, 6'd63);
    test_random_play(50);
    set_config(16'd1, 6'd0, 6'd0);
    test_random_play(50);
    set_config(16'd5, 6'd2, 6'd10);
    test_random_play(60);

    drain();
    $display("run: %0d items sent, %0d result beats checked, %0d disconnects", items_sent,
             beats_seen, drops_seen);
    $display("covered connect flow, duplicate inputs, pacing, lag drop, timeouts, backpressure");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
